// ===== rtl/erm_pkg.sv =====
// Shared widths, packing constants and sine table generator for the rotation matrix builder.
package erm_pkg;

	localparam int ANGLE_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 12;

	// fixed port field widths
	localparam int ANGLE_W   = 16;
	localparam int ELEM_W_WIDE   = 15;
	localparam int ELEM_W_NARROW = 14;

	localparam int S_TDATA_W = 3 * ANGLE_W;
	localparam int M_DATA_BITS = 5 * ELEM_W_NARROW + 4 * ELEM_W_WIDE;
	localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;
	localparam int M_PAD_W   = M_TDATA_W - M_DATA_BITS;

	localparam real PI = 3.14159265358979323846;

	// round(2^fbits * sin(2*pi*idx / 2^abits)), built from the first quarter so the
	// table is exactly odd and mirror symmetric
	function automatic int sine_value(int idx, int abits, int fbits);
		int  half;
		int  quarter;
		int  j;
		bit  neg;
		real v;
		int  r;
		half    = 1 << (abits - 1);
		quarter = 1 << (abits - 2);
		j       = idx & (half - 1);
		neg     = (idx & half) != 0;
		if (j > quarter) begin
			j = half - j;
		end
		v = (2.0 ** fbits) * $sin(PI * real'(j) * (2.0 ** (1 - abits)));
		r = $rtoi(v + 0.5);
		if (j == 0) begin
			r = 0;
		end
		return neg ? -r : r;
	endfunction

endpackage

// ===== rtl/euler_rotation_matrix.sv =====
// Euler-angle rotation matrix builder: four-stage pipeline from three angles to nine elements.
//
// Input channel s_*: one word carries three 16-bit angles; only the low ANGLE_BITS
// bits of each are used (2^ANGLE_BITS steps per turn).
// Output channel m_*: one word carries the nine signed elements (3.12 and 2.12) of the 3x3
// rotation matrix for that angle triple.
// Pipeline: stage 1 reads sine and cosine of each angle from constant sine ROMs
// (registered read, cosine is the entry a quarter turn further on); stage 2 forms
// the first products; stage 3 the second-level products; stage 4 sums, shifts and
// holds the output word.
// Path: a word accepted on s_* is registered in stages 1, 2, 3 and 4 in turn;
// m_tdata is driven from the stage 4 registers.
// Throughput: one word per cycle while m_tready is high; each stage has its own valid bit and advances
// whenever the stage after it is empty or moving, so bubbles are squeezed out and
// input is still taken while a finished word waits at the output.
// Stall: with m_tready low the output word holds, the stages behind it fill up, and
// s_tready drops only once all four stages hold words. Nothing is lost or repeated.
// Reset: arst_n clears all valid bits; the ROM contents are constant.
module euler_rotation_matrix
	import erm_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// angle_a [15:0], angle_b [31:16], angle_c [47:32]
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// element_0 [14:0], element_1 [29:15], element_2 [43:30], element_3 [57:44],
	// element_4 [71:58], element_5 [85:72], element_6 [100:86], element_7 [115:101],
	// element_8 [129:116], zero pad [135:130]
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int TABLE_SIZE = 1 << ANGLE_BITS;
	localparam int SW   = FRAC_BITS + 2;
	localparam int PW   = 2 * SW;
	localparam int SUMW = PW + 1;
	localparam int ONE  = 1 << FRAC_BITS;
	localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

	typedef logic signed [SW-1:0] sine_t;
	typedef sine_t rom_t [TABLE_SIZE];
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [ELEM_W_NARROW-1:0] elem_n_t;
	typedef logic signed [ELEM_W_WIDE-1:0] elem_w_t;

	function automatic rom_t build_rom();
		rom_t t;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			t[i] = SW'(sine_value(i, ANGLE_BITS, FRAC_BITS));
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// stage enables: a stage loads when it is empty or the next one loads
	logic en_s1, en_s2, en_s3, en_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	assign en_s4 = !valid_s4 || m_tready;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = valid_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_tvalid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// ---------------- stage 1: ROM reads
	logic [ANGLE_BITS-1:0] ang_a, ang_b, ang_c;
	sine_t sa_s1, sb_s1, sc_s1, ca_s1, cb_s1, cc_s1;

	assign ang_a = s_tdata[ANGLE_BITS-1:0];
	assign ang_b = s_tdata[ANGLE_W+ANGLE_BITS-1:ANGLE_W];
	assign ang_c = s_tdata[2*ANGLE_W+ANGLE_BITS-1:2*ANGLE_W];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sa_s1 <= SINE_ROM[ang_a];
			sb_s1 <= SINE_ROM[ang_b];
			sc_s1 <= SINE_ROM[ang_c];
			ca_s1 <= SINE_ROM[ang_a + QUARTER];
			cb_s1 <= SINE_ROM[ang_b + QUARTER];
			cc_s1 <= SINE_ROM[ang_c + QUARTER];
		end
	end

	// ---------------- stage 2: first products
	prod_t p_sab, p_sacb, p_casb, p_casc, p_cacc, p_cacb;
	prod_t p_cbcc, p_cbsc, p_sbcc, p_sbsc;

	assign p_sab  = PW'(sa_s1) * PW'(sb_s1);
	assign p_sacb = PW'(sa_s1) * PW'(cb_s1);
	assign p_casb = PW'(ca_s1) * PW'(sb_s1);
	assign p_casc = PW'(ca_s1) * PW'(sc_s1);
	assign p_cacc = PW'(ca_s1) * PW'(cc_s1);
	assign p_cacb = PW'(ca_s1) * PW'(cb_s1);
	assign p_cbcc = PW'(cb_s1) * PW'(cc_s1);
	assign p_cbsc = PW'(cb_s1) * PW'(sc_s1);
	assign p_sbcc = PW'(sb_s1) * PW'(cc_s1);
	assign p_sbsc = PW'(sb_s1) * PW'(sc_s1);

	sine_t   sab_s2, sacb_s2, sc_s2, cc_s2;
	prod_t   cbcc_s2, cbsc_s2, sbcc_s2, sbsc_s2;
	elem_n_t e2_s2, e3_s2, e4_s2, e5_s2, e8_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sab_s2  <= SW'(p_sab >>> FRAC_BITS);
			sacb_s2 <= SW'(p_sacb >>> FRAC_BITS);
			sc_s2   <= sc_s1;
			cc_s2   <= cc_s1;
			cbcc_s2 <= p_cbcc;
			cbsc_s2 <= p_cbsc;
			sbcc_s2 <= p_sbcc;
			sbsc_s2 <= p_sbsc;
			e2_s2   <= ELEM_W_NARROW'(p_casb >>> FRAC_BITS);
			e3_s2   <= ELEM_W_NARROW'(p_casc >>> FRAC_BITS);
			e4_s2   <= ELEM_W_NARROW'(p_cacc >>> FRAC_BITS);
			e5_s2   <= ELEM_W_NARROW'(-sa_s1);
			e8_s2   <= ELEM_W_NARROW'(p_cacb >>> FRAC_BITS);
		end
	end

	// ---------------- stage 3: second-level products
	prod_t   p0_s3, p1_s3, p6_s3, p7_s3;
	prod_t   cbcc_s3, cbsc_s3, sbcc_s3, sbsc_s3;
	elem_n_t e2_s3, e3_s3, e4_s3, e5_s3, e8_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			p0_s3   <= PW'(sab_s2) * PW'(sc_s2);
			p1_s3   <= PW'(sab_s2) * PW'(cc_s2);
			p6_s3   <= PW'(sacb_s2) * PW'(sc_s2);
			p7_s3   <= PW'(sacb_s2) * PW'(cc_s2);
			cbcc_s3 <= cbcc_s2;
			cbsc_s3 <= cbsc_s2;
			sbcc_s3 <= sbcc_s2;
			sbsc_s3 <= sbsc_s2;
			e2_s3   <= e2_s2;
			e3_s3   <= e3_s2;
			e4_s3   <= e4_s2;
			e5_s3   <= e5_s2;
			e8_s3   <= e8_s2;
		end
	end

	// ---------------- stage 4: sums, floor shift, output word
	logic signed [SUMW-1:0] sum0, sum1, sum6, sum7;

	assign sum0 = SUMW'(p0_s3) + SUMW'(cbcc_s3);
	assign sum1 = SUMW'(p1_s3) - SUMW'(cbsc_s3);
	assign sum6 = SUMW'(p6_s3) - SUMW'(sbcc_s3);
	assign sum7 = SUMW'(p7_s3) + SUMW'(sbsc_s3);

	elem_w_t e0_s4, e1_s4, e6_s4, e7_s4;
	elem_n_t e2_s4, e3_s4, e4_s4, e5_s4, e8_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			e0_s4 <= ELEM_W_WIDE'(sum0 >>> FRAC_BITS);
			e1_s4 <= ELEM_W_WIDE'(sum1 >>> FRAC_BITS);
			e6_s4 <= ELEM_W_WIDE'(sum6 >>> FRAC_BITS);
			e7_s4 <= ELEM_W_WIDE'(sum7 >>> FRAC_BITS);
			e2_s4 <= e2_s3;
			e3_s4 <= e3_s3;
			e4_s4 <= e4_s3;
			e5_s4 <= e5_s3;
			e8_s4 <= e8_s3;
		end
	end

	assign m_tdata = {{M_PAD_W{1'b0}}, e8_s4, e7_s4, e6_s4, e5_s4, e4_s4, e3_s4,
		e2_s4, e1_s4, e0_s4};

	// ---------------- checks
	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_tready))
		else $error("input stalled while a pipeline stage is free");

	a_s3_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_s4) |=> m_tvalid)
		else $error("word in stage 3 did not reach the output");

	a_rom_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (sa_s1 <= ONE && sa_s1 >= -ONE && ca_s1 <= ONE && ca_s1 >= -ONE))
		else $error("sine ROM value out of range");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (e2_s4 <= ONE && e2_s4 >= -ONE && e5_s4 <= ONE && e5_s4 >= -ONE))
		else $error("single-product element out of range");

endmodule

// ===== verif/testbench.sv =====
// Stimulus, prediction and checking for the Euler-angle rotation matrix builder.
module testbench;
	import erm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TURN      = 4096;
	localparam int QTR       = TURN / 4;
	localparam int FRAC      = 12;
	localparam int LIMIT     = 200000;
	localparam int TAIL_WAIT = 8;
	localparam real TWO_PI   = 6.28318530717958647692;

	// one output word, element_0 in the low bits
	typedef struct packed {
		logic [M_PAD_W-1:0]              pad;
		logic signed [ELEM_W_NARROW-1:0] e8;
		logic signed [ELEM_W_WIDE-1:0]   e7;
		logic signed [ELEM_W_WIDE-1:0]   e6;
		logic signed [ELEM_W_NARROW-1:0] e5;
		logic signed [ELEM_W_NARROW-1:0] e4;
		logic signed [ELEM_W_NARROW-1:0] e3;
		logic signed [ELEM_W_NARROW-1:0] e2;
		logic signed [ELEM_W_WIDE-1:0]   e1;
		logic signed [ELEM_W_WIDE-1:0]   e0;
	} matrix_word_t;

	class matrix_scoreboard;
		longint sine_tbl[TURN];
		int elem_lsb[10];
		matrix_word_t pending_matrices[$];
		int errors;

		function new();
			int i;
			longint v;
			for (i = 0; i <= QTR; i++) begin
				v = longint'($floor(4096.0 * $sin(TWO_PI * real'(i) / real'(TURN)) + 0.5));
				sine_tbl[i] = v;
				sine_tbl[(2 * QTR - i) % TURN] = v;
				sine_tbl[(2 * QTR + i) % TURN] = -v;
				sine_tbl[(4 * QTR - i) % TURN] = -v;
			end
			sine_tbl[0] = 0;
			sine_tbl[2 * QTR] = 0;
			elem_lsb = '{0, 15, 30, 44, 58, 72, 86, 101, 116, 130};
			errors = 0;
		endfunction

		function int pending();
			return pending_matrices.size();
		endfunction

		task report_mismatch(input string msg);
			if (errors < 100) begin
				$display("tb: mismatch: %s", msg);
			end
			errors++;
		endtask

		// accepted input word: compute the rotation matrix it should produce
		function void note_angles(input logic [S_TDATA_W-1:0] angles);
			int a, b, c;
			longint sa, sb, sc, ca, cb, cc, sab, sacb;
			matrix_word_t m;
			a = int'(angles[11:0]);
			b = int'(angles[ANGLE_W+11:ANGLE_W]);
			c = int'(angles[2*ANGLE_W+11:2*ANGLE_W]);
			sa = sine_tbl[a];
			sb = sine_tbl[b];
			sc = sine_tbl[c];
			ca = sine_tbl[(a + QTR) % TURN];
			cb = sine_tbl[(b + QTR) % TURN];
			cc = sine_tbl[(c + QTR) % TURN];
			sab = (sa * sb) >>> FRAC;
			sacb = (sa * cb) >>> FRAC;
			m = '0;
			m.e0 = ELEM_W_WIDE'((sab * sc + cb * cc) >>> FRAC);
			m.e1 = ELEM_W_WIDE'((sab * cc - cb * sc) >>> FRAC);
			m.e2 = ELEM_W_NARROW'((ca * sb) >>> FRAC);
			m.e3 = ELEM_W_NARROW'((ca * sc) >>> FRAC);
			m.e4 = ELEM_W_NARROW'((ca * cc) >>> FRAC);
			m.e5 = ELEM_W_NARROW'(-sa);
			m.e6 = ELEM_W_WIDE'((sacb * sc - sb * cc) >>> FRAC);
			m.e7 = ELEM_W_WIDE'((sacb * cc + sb * sc) >>> FRAC);
			m.e8 = ELEM_W_NARROW'((ca * cb) >>> FRAC);
			pending_matrices.push_back(m);
		endfunction

		function int elem(input logic [M_TDATA_W-1:0] w, input int k);
			int width;
			logic [M_TDATA_W-1:0] sh;
			int v;
			width = elem_lsb[k + 1] - elem_lsb[k];
			sh = w >> elem_lsb[k];
			v = int'(sh[14:0]) & ((1 << width) - 1);
			if (v >= (1 << (width - 1))) begin
				v -= 1 << width;
			end
			return v;
		endfunction

		task check_matrix(input logic [M_TDATA_W-1:0] got);
			matrix_word_t want;
			int k;
			if (pending_matrices.size() == 0) begin
				report_mismatch($sformatf("word %h with nothing expected", got));
				return;
			end
			want = pending_matrices.pop_front();
			for (k = 0; k < 9; k++) begin
				if (elem(got, k) != elem(want, k)) begin
					report_mismatch($sformatf("element_%0d got %0d want %0d",
						k, elem(got, k), elem(want, k)));
				end
			end
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;

	matrix_scoreboard sb;
	int tx_max_gap;
	int rx_max_gap;
	int rx_hold;
	int cycles;

	euler_rotation_matrix u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			sb.check_matrix(m_tdata);
		end
	end

	// receiver: random back-pressure per word, or a long hold when asked
	initial begin
		int wait_cycles;
		@(posedge arst_n);
		forever begin
			if (rx_hold > 0) begin
				wait_cycles = rx_hold;
				rx_hold = 0;
			end else begin
				wait_cycles = $urandom_range(0, rx_max_gap);
			end
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	function automatic logic [ANGLE_W-1:0] rand_angle();
		logic [ANGLE_W-1:0] hi;
		int pick;
		hi = ANGLE_W'($urandom_range(0, 15)) << 12;
		pick = $urandom_range(0, 9);
		if (pick < 6) begin
			return ANGLE_W'($urandom_range(0, 65535));
		end else if (pick < 8) begin
			// quarter-turn points and their neighbors
			return hi | ANGLE_W'((QTR * $urandom_range(0, 3) + $urandom_range(0, 6) - 3)
				& (TURN - 1));
		end
		return hi | ANGLE_W'($urandom_range(0, TURN - 1));
	endfunction

	task send_angles(input logic [ANGLE_W-1:0] a, input logic [ANGLE_W-1:0] b,
		input logic [ANGLE_W-1:0] c);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {c, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_angles({c, b, a});
	endtask

	task send_random(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_angles(rand_angle(), rand_angle(), rand_angle());
		end
	endtask

	task wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	initial begin
		sb = new();
		cycles = 0;
		rx_hold = 0;
		tx_max_gap = 14;
		rx_max_gap = 14;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, all ones, quarter turns, wrap of the cosine index, unused bits
		send_angles(16'h0000, 16'h0000, 16'h0000);
		send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_angles(16'd1024, 16'd0, 16'd0);
		send_angles(16'd0, 16'd1024, 16'd0);
		send_angles(16'd0, 16'd0, 16'd1024);
		send_angles(16'd2048, 16'd2048, 16'd2048);
		send_angles(16'd3072, 16'd3072, 16'd3072);
		send_angles(16'd4095, 16'd4095, 16'd4095);
		send_angles(16'h1000, 16'h2000, 16'hF000);
		send_angles(16'h1400, 16'h2800, 16'h3C00);
		send_angles(16'd512, 16'd512, 16'd512);
		send_angles(16'd1, 16'd2, 16'd3);
		send_angles(16'd3071, 16'd3073, 16'd1023);
		send_angles(16'd1025, 16'd2047, 16'd2049);
		send_angles(16'hAAAA, 16'h5555, 16'h0F0F);
		send_angles(16'h5555, 16'hAAAA, 16'hF0F0);
		send_angles(16'd341, 16'd1707, 16'd2731);
		send_angles(16'd3000, 16'd100, 16'd2000);

		send_random(150);

		// back to back on both sides
		tx_max_gap = 0;
		rx_max_gap = 0;
		send_random(100);

		// long output stall while input keeps coming, so the pipe fills
		rx_hold = 80;
		send_random(30);
		s_tvalid <= 1'b0;
		wait_drained();

		tx_max_gap = 14;
		rx_max_gap = 14;
		send_random(90);
		tx_max_gap = 3;
		rx_max_gap = 6;
		send_random(80);
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/erm_pkg.sv
rtl/euler_rotation_matrix.sv
verif/testbench.sv
